[src/lpws_pkg.sv]
// Package for the LCD pixel write sequencer: types, command codes and the microcode program.
`timescale 1ns / 1ps
`default_nettype none
package lpws_pkg;

	localparam int COORD_W = 16;
	localparam int COLOR_W = 16;
	localparam int BYTE_W  = 8;

	localparam int PANEL_WIDTH_DEF  = 240;
	localparam int PANEL_HEIGHT_DEF = 320;

	// Program length: one bounds check, then nineteen bus beats.
	localparam int NUM_STEPS = 20;
	localparam int STEP_W    = $clog2(NUM_STEPS);

	// Panel command registers.
	localparam logic [BYTE_W-1:0] CMD_COL_START_HI = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_COL_START_LO = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_COL_END_HI   = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_COL_END_LO   = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_ROW_START_HI = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_ROW_START_LO = 8'h07;
	localparam logic [BYTE_W-1:0] CMD_ROW_END_HI   = 8'h08;
	localparam logic [BYTE_W-1:0] CMD_ROW_END_LO   = 8'h09;
	localparam logic [BYTE_W-1:0] CMD_MEM_WRITE    = 8'h22;

	typedef enum logic [1:0] {
		OP_CHECK,
		OP_EMIT,
		OP_HALT
	} op_t;

	typedef enum logic [2:0] {
		SRC_CONST,
		SRC_X_HI,
		SRC_X_LO,
		SRC_Y_HI,
		SRC_Y_LO,
		SRC_C_HI,
		SRC_C_LO
	} src_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		op_t               op;
		logic              is_data;
		src_t              src;
		logic [BYTE_W-1:0] cbyte;
		logic              last;
		logic              fin;
	} ucode_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic              load;
		logic              emit;
		logic              is_data;
		src_t              src;
		logic [BYTE_W-1:0] cbyte;
		logic              last;
	} ctrl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic in_bounds;
		logic out_free;
	} stat_t;

	function automatic ucode_t cmd_word(input logic [BYTE_W-1:0] cmd);
		ucode_t w;
		w = '{op: OP_EMIT, is_data: 1'b0, src: SRC_CONST, cbyte: cmd, last: 1'b0, fin: 1'b0};
		return w;
	endfunction

	function automatic ucode_t data_word(input src_t src);
		ucode_t w;
		w = '{op: OP_EMIT, is_data: 1'b1, src: src, cbyte: '0, last: 1'b0, fin: 1'b0};
		return w;
	endfunction

	// The control store: one word per step.
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{op: OP_HALT, is_data: 1'b0, src: SRC_CONST, cbyte: '0, last: 1'b0, fin: 1'b1};
		case (step)
			5'd0:  w = '{op: OP_CHECK, is_data: 1'b0, src: SRC_CONST, cbyte: '0,
				last: 1'b0, fin: 1'b0};
			5'd1:  w = cmd_word(CMD_COL_START_HI);
			5'd2:  w = data_word(SRC_X_HI);
			5'd3:  w = cmd_word(CMD_COL_START_LO);
			5'd4:  w = data_word(SRC_X_LO);
			5'd5:  w = cmd_word(CMD_COL_END_HI);
			5'd6:  w = data_word(SRC_X_HI);
			5'd7:  w = cmd_word(CMD_COL_END_LO);
			5'd8:  w = data_word(SRC_X_LO);
			5'd9:  w = cmd_word(CMD_ROW_START_HI);
			5'd10: w = data_word(SRC_Y_HI);
			5'd11: w = cmd_word(CMD_ROW_START_LO);
			5'd12: w = data_word(SRC_Y_LO);
			5'd13: w = cmd_word(CMD_ROW_END_HI);
			5'd14: w = data_word(SRC_Y_HI);
			5'd15: w = cmd_word(CMD_ROW_END_LO);
			5'd16: w = data_word(SRC_Y_LO);
			5'd17: w = cmd_word(CMD_MEM_WRITE);
			5'd18: w = data_word(SRC_C_HI);
			5'd19: begin
				w = data_word(SRC_C_LO);
				w.last = 1'b1;
				w.fin = 1'b1;
			end
			default: w = '{op: OP_HALT, is_data: 1'b0, src: SRC_CONST, cbyte: '0,
				last: 1'b0, fin: 1'b1};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[src/lpws_if.sv]
// Handshake channel interfaces for pixel requests and bus beats.
`timescale 1ns / 1ps
`default_nettype none
interface lpws_pixel_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [lpws_pkg::COORD_W-1:0]      pixel_x;
	logic signed [lpws_pkg::COORD_W-1:0]      pixel_y;
	logic        [lpws_pkg::COLOR_W-1:0]      pixel_color;

	modport source (output valid, pixel_x, pixel_y, pixel_color, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, output ready);
endinterface

interface lpws_beat_if;
	logic                        valid;
	logic                        ready;
	logic                        is_data;
	logic [lpws_pkg::BYTE_W-1:0] bus_byte;
	logic                        last_beat;

	modport source (output valid, is_data, bus_byte, last_beat, input ready);
	modport sink (input valid, is_data, bus_byte, last_beat, output ready);
endinterface
`default_nettype wire

[src/lpws_seq.sv]
// Microcode sequencer: step counter, control store fetch and conditional jump.
`timescale 1ns / 1ps
`default_nettype none
module lpws_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lpws_pkg::stat_t stat,
	output lpws_pkg::ctrl_t      ctrl
);

	lpws_pkg::seq_state_t              state_q, state_d;
	logic [lpws_pkg::STEP_W-1:0]       step_q, step_d;
	lpws_pkg::ucode_t                  word;

	assign word = lpws_pkg::ucode(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpws_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		in_ready      = 1'b0;
		ctrl.load     = 1'b0;
		ctrl.emit     = 1'b0;
		ctrl.is_data  = word.is_data;
		ctrl.src      = word.src;
		ctrl.cbyte    = word.cbyte;
		ctrl.last     = word.last;
		case (state_q)
			lpws_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					step_d    = '0;
					state_d   = lpws_pkg::ST_RUN;
				end
			end
			lpws_pkg::ST_RUN: begin
				case (word.op)
					lpws_pkg::OP_CHECK: begin
						// Out-of-panel pixels jump straight back to idle.
						if (stat.in_bounds) begin
							step_d = step_q + 1'b1;
						end else begin
							state_d = lpws_pkg::ST_IDLE;
						end
					end
					lpws_pkg::OP_EMIT: begin
						if (stat.out_free) begin
							ctrl.emit = 1'b1;
							if (word.fin) begin
								state_d = lpws_pkg::ST_IDLE;
							end else begin
								step_d = step_q + 1'b1;
							end
						end
					end
					default: state_d = lpws_pkg::ST_IDLE;
				endcase
			end
			default: state_d = lpws_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[src/lpws_dp.sv]
// Datapath: request registers, panel bounds check, byte select and output register.
`timescale 1ns / 1ps
`default_nettype none
module lpws_dp #(
	parameter int PANEL_WIDTH  = lpws_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = lpws_pkg::PANEL_HEIGHT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lpws_pkg::ctrl_t                     ctrl,
	output lpws_pkg::stat_t                          stat,
	input  wire logic signed [lpws_pkg::COORD_W-1:0] pixel_x,
	input  wire logic signed [lpws_pkg::COORD_W-1:0] pixel_y,
	input  wire logic        [lpws_pkg::COLOR_W-1:0] pixel_color,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     is_data,
	output logic             [lpws_pkg::BYTE_W-1:0]  bus_byte,
	output logic                                     last_beat
);

	logic signed [lpws_pkg::COORD_W-1:0] x_q, y_q;
	logic        [lpws_pkg::COLOR_W-1:0] color_q;
	logic                                out_valid_q;
	logic                                is_data_q, last_q;
	logic        [lpws_pkg::BYTE_W-1:0]  byte_q;
	logic        [lpws_pkg::BYTE_W-1:0]  sel_byte;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q     <= pixel_x;
			y_q     <= pixel_y;
			color_q <= pixel_color;
		end
	end

	// Coordinates are non-negative and below the panel size.
	assign stat.in_bounds = !x_q[lpws_pkg::COORD_W-1] && !y_q[lpws_pkg::COORD_W-1]
		&& ({1'b0, x_q} < (lpws_pkg::COORD_W+1)'(PANEL_WIDTH))
		&& ({1'b0, y_q} < (lpws_pkg::COORD_W+1)'(PANEL_HEIGHT));
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		case (ctrl.src)
			lpws_pkg::SRC_X_HI: sel_byte = x_q[15:8];
			lpws_pkg::SRC_X_LO: sel_byte = x_q[7:0];
			lpws_pkg::SRC_Y_HI: sel_byte = y_q[15:8];
			lpws_pkg::SRC_Y_LO: sel_byte = y_q[7:0];
			lpws_pkg::SRC_C_HI: sel_byte = color_q[15:8];
			lpws_pkg::SRC_C_LO: sel_byte = color_q[7:0];
			default:            sel_byte = ctrl.cbyte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			is_data_q <= ctrl.is_data;
			byte_q    <= sel_byte;
			last_q    <= ctrl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign is_data   = is_data_q;
	assign bus_byte  = byte_q;
	assign last_beat = last_q;

endmodule
`default_nettype wire

[src/lcd_pixel_write_sequencer.sv]
// Top level of the LCD pixel write sequencer: sequencer, datapath and checks.
// The first beat of an accepted pixel appears after its transfer once the bounds check
// and the first emit step have run and the beat sits in the output register.
// Throughput: one beat per cycle while the output is not stalled. An in-panel pixel passes
// through the idle state at its transfer, one check step and 19 beat steps; an off-panel pixel gives no beats.
// A stall on the output holds the sequencer on its current emit step.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module lcd_pixel_write_sequencer #(
	parameter int PANEL_WIDTH  = lpws_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = lpws_pkg::PANEL_HEIGHT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lpws_pixel_if.sink    pix_in,
	lpws_beat_if.source   beat_out
);

	// Control words flow from the sequencer to the datapath; status flows back.
	lpws_pkg::ctrl_t ctrl;
	lpws_pkg::stat_t stat;

	// The sequencer walks the control store one step per cycle. The first step checks
	// the latched coordinates against the panel and jumps back to idle when the pixel
	// lies outside; each later step emits one bus beat, holding while the output
	// register is still full.
	lpws_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// The datapath latches the request on a transfer, selects the byte named by the
	// control word and holds the beat in an output register, so the final beat can
	// wait on the bus side while the next pixel is already taken.
	lpws_dp #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.pixel_x     (pix_in.pixel_x),
		.pixel_y     (pix_in.pixel_y),
		.pixel_color (pix_in.pixel_color),
		.out_valid   (beat_out.valid),
		.out_ready   (beat_out.ready),
		.is_data     (beat_out.is_data),
		.bus_byte    (beat_out.bus_byte),
		.last_beat   (beat_out.last_beat)
	);

	// The closing beat of a run is always a colour data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat_out.valid && beat_out.last_beat |-> beat_out.is_data)
		else $error("last beat is not a data byte");

	// A command beat carries one of the panel's command codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat_out.valid && !beat_out.is_data |->
		(beat_out.bus_byte == lpws_pkg::CMD_COL_START_HI) ||
		(beat_out.bus_byte == lpws_pkg::CMD_COL_START_LO) ||
		(beat_out.bus_byte == lpws_pkg::CMD_COL_END_HI) ||
		(beat_out.bus_byte == lpws_pkg::CMD_COL_END_LO) ||
		(beat_out.bus_byte == lpws_pkg::CMD_ROW_START_HI) ||
		(beat_out.bus_byte == lpws_pkg::CMD_ROW_START_LO) ||
		(beat_out.bus_byte == lpws_pkg::CMD_ROW_END_HI) ||
		(beat_out.bus_byte == lpws_pkg::CMD_ROW_END_LO) ||
		(beat_out.bus_byte == lpws_pkg::CMD_MEM_WRITE))
		else $error("command beat with unknown command code");

	// After a pixel transfer the sequencer is busy with the bounds check.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> !pix_in.ready)
		else $error("new pixel taken before the bounds check");

	// A beat is never loaded in the cycle right after a pixel transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> !ctrl.emit)
		else $error("beat emitted before the bounds check");

endmodule
`default_nettype wire

[tb/sv/tb_lcd_pixel_write_sequencer.sv]
// Self-checking testbench for the LCD pixel write sequencer: pixel requests in, bus beats checked.
`timescale 1ns / 1ps
module tb_lcd_pixel_write_sequencer;

	// The block is built with its default panel size, and the predictor uses the same figures.
	localparam int PANEL_W     = lpws_pkg::PANEL_WIDTH_DEF;
	localparam int PANEL_H     = lpws_pkg::PANEL_HEIGHT_DEF;
	// Cycles to watch for stray beats once nothing is outstanding. The first beat follows
	// its transfer after the bounds check, and an off-panel pixel only passes through the check.
	localparam int DRAIN_TAIL  = 40;
	// Length of the long output stall, well beyond one 19-beat window write.
	localparam int HOLD_CYCLES = 300;
	// Bound on the wait for outstanding beats at the end of a phase.
	localparam int DRAIN_LIMIT = 20000;
	// Whole-run guard. The slowest correct run is about 260 pixels, stretched by idling on
	// both sides and the long stall.
	localparam int RUN_LIMIT_NS = 2_000_000;
	// Chance, in percent, that either side idles on a given cycle.
	localparam int IDLE_PCT    = 29;

	// One bus beat as seen on the output channel.
	typedef struct packed {
		logic                        is_data;
		logic [lpws_pkg::BYTE_W-1:0] bus_byte;
		logic                        last_beat;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpws_pixel_if pix ();
	lpws_beat_if  beat ();

	lcd_pixel_write_sequencer #(
		.PANEL_WIDTH  (PANEL_W),
		.PANEL_HEIGHT (PANEL_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix),
		.beat_out (beat)
	);

	always #5 clk = ~clk;

	// Beats still owed by the block, oldest first.
	beat_t pending_beats[$];

	// Idling controls. The receiver's flags are written with nonblocking assignments, as the
	// receiver process samples them at the same clock edge.
	logic src_idle_en  = 1'b1;
	logic sink_idle_en = 1'b1;
	logic stall_hold   = 1'b0;

	int err_count        = 0;
	int pixels_in_panel  = 0;
	int pixels_off_panel = 0;
	int beats_checked    = 0;

	task automatic report_mismatch(input string msg);
		if (err_count < 20)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	function automatic void push_beat(input logic is_data,
		input logic [lpws_pkg::BYTE_W-1:0] b, input logic last);
		beat_t nb;
		nb.is_data   = is_data;
		nb.bus_byte  = b;
		nb.last_beat = last;
		pending_beats.push_back(nb);
	endfunction

	// Works out the beats of one pixel request. A pixel off the panel produces nothing.
	// Otherwise the column and row windows are both narrowed to the single pixel, each
	// register write being a command byte followed by the high or low coordinate byte,
	// then the memory write command and the two colour bytes, the last one flagged.
	task automatic predict_window_write(input logic signed [lpws_pkg::COORD_W-1:0] x,
		input logic signed [lpws_pkg::COORD_W-1:0] y,
		input logic [lpws_pkg::COLOR_W-1:0] color);
		logic [lpws_pkg::COORD_W-1:0] ux;
		logic [lpws_pkg::COORD_W-1:0] uy;
		if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_H) begin
			pixels_off_panel++;
			return;
		end
		pixels_in_panel++;
		ux = x;
		uy = y;
		push_beat(1'b0, lpws_pkg::CMD_COL_START_HI, 1'b0);
		push_beat(1'b1, ux[15:8], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_COL_START_LO, 1'b0);
		push_beat(1'b1, ux[7:0], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_COL_END_HI, 1'b0);
		push_beat(1'b1, ux[15:8], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_COL_END_LO, 1'b0);
		push_beat(1'b1, ux[7:0], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_ROW_START_HI, 1'b0);
		push_beat(1'b1, uy[15:8], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_ROW_START_LO, 1'b0);
		push_beat(1'b1, uy[7:0], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_ROW_END_HI, 1'b0);
		push_beat(1'b1, uy[15:8], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_ROW_END_LO, 1'b0);
		push_beat(1'b1, uy[7:0], 1'b0);
		push_beat(1'b0, lpws_pkg::CMD_MEM_WRITE, 1'b0);
		push_beat(1'b1, color[15:8], 1'b0);
		push_beat(1'b1, color[7:0], 1'b1);
	endtask

	// Offers one pixel request and returns at the edge of its transfer. Valid is left high,
	// so back-to-back requests keep it high without a glitch; an idle cycle lowers it.
	task automatic send_pixel(input logic signed [lpws_pkg::COORD_W-1:0] x,
		input logic signed [lpws_pkg::COORD_W-1:0] y,
		input logic [lpws_pkg::COLOR_W-1:0] color);
		while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel_x     <= x;
		pix.pixel_y     <= y;
		pix.pixel_color <= color;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		predict_window_write(x, y, color);
	endtask

	// The sender stops offering and waits until every owed beat has arrived.
	task automatic wait_drained();
		int guard;
		guard = 0;
		pix.valid <= 1'b0;
		while (pending_beats.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));
	endtask

	// Mostly pixels on the panel, with a share near and beyond each edge and some fully
	// random coordinates, which are nearly always off the panel.
	task automatic send_random_pixel(input bit on_panel_only);
		int pick;
		logic signed [lpws_pkg::COORD_W-1:0] x;
		logic signed [lpws_pkg::COORD_W-1:0] y;
		pick = on_panel_only ? 0 : $urandom_range(0, 99);
		x = $urandom_range(0, PANEL_W - 1);
		y = $urandom_range(0, PANEL_H - 1);
		if (pick < 10) begin
			// Corners, and rows either side of the high byte turning over.
			x = $urandom_range(0, 1) ? 0 : PANEL_W - 1;
			case ($urandom_range(0, 3))
				0: y = 0;
				1: y = 255;
				2: y = 256;
				default: y = PANEL_H - 1;
			endcase
		end else if (pick < 70) begin
			// Plain pixel on the panel, already chosen.
		end else if (pick < 85) begin
			// Just off one edge.
			case ($urandom_range(0, 3))
				0: x = -1;
				1: x = PANEL_W;
				2: y = -1;
				default: y = PANEL_H;
			endcase
		end else begin
			x = $urandom_range(0, 16'hFFFF);
			y = $urandom_range(0, 16'hFFFF);
		end
		send_pixel(x, y, $urandom_range(0, 16'hFFFF));
	endtask

	// Edges of the panel, every way of falling off it, the extremes of the signed range and
	// colours that toggle every bit.
	task automatic test_corner_pixels();
		send_pixel(0, 0, 16'h0000);
		send_pixel(PANEL_W - 1, PANEL_H - 1, 16'hFFFF);
		send_pixel(PANEL_W - 1, 0, 16'hA5A5);
		send_pixel(0, PANEL_H - 1, 16'h5A5A);
		send_pixel(128, 255, 16'h8000);
		send_pixel(127, 256, 16'h0001);
		send_pixel(-1, 0, 16'h1234);
		send_pixel(0, -1, 16'h1234);
		send_pixel(-1, -1, 16'hFFFF);
		send_pixel(PANEL_W, 0, 16'h4321);
		send_pixel(0, PANEL_H, 16'h4321);
		send_pixel(PANEL_W, PANEL_H, 16'h0F0F);
		send_pixel(-32768, -32768, 16'hF0F0);
		send_pixel(32767, 32767, 16'h00FF);
		send_pixel(32767, 0, 16'hFF00);
		send_pixel(0, 32767, 16'h7FFF);
		send_pixel(-32768, 5, 16'h3C3C);
		send_pixel(5, -32768, 16'hC3C3);
		send_pixel(PANEL_W - 1, 256, 16'hFFFE);
		send_pixel(1, 1, 16'h8001);
		wait_drained();
	endtask

	task automatic test_random_pixels(input int n);
		repeat (n)
			send_random_pixel(1'b0);
		wait_drained();
	endtask

	// The receiver stalls for a long stretch in a process of its own while the sender keeps
	// offering, so the block fills up and holds off its input; then the sender pauses.
	task automatic test_output_hold();
		fork
			begin
				stall_hold <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				stall_hold <= 1'b0;
			end
		join_none
		repeat (10)
			send_random_pixel(1'b1);
		wait_drained();
	endtask

	// A long stretch with neither side idling: beats leave at full rate and requests follow
	// each other as closely as the block allows.
	task automatic test_steady_stream(input int n);
		src_idle_en  <= 1'b0;
		sink_idle_en <= 1'b0;
		repeat (n)
			send_random_pixel(1'b0);
		wait_drained();
		src_idle_en  <= 1'b1;
		sink_idle_en <= 1'b1;
	endtask

	// Receiver: checks each beat transfer against the oldest owed beat, then chooses its
	// ready for the next cycle.
	initial begin : beat_sink
		beat_t want;
		beat.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (beat.valid && beat.ready) begin
					if (pending_beats.size() == 0) begin
						report_mismatch($sformatf("unexpected beat is_data=%0b byte=%02h last=%0b",
							beat.is_data, beat.bus_byte, beat.last_beat));
					end else begin
						want = pending_beats.pop_front();
						beats_checked++;
						if (beat.is_data !== want.is_data)
							report_mismatch($sformatf("is_data %0b, wanted %0b",
								beat.is_data, want.is_data));
						if (beat.bus_byte !== want.bus_byte)
							report_mismatch($sformatf("bus_byte %02h, wanted %02h",
								beat.bus_byte, want.bus_byte));
						if (beat.last_beat !== want.last_beat)
							report_mismatch($sformatf("last_beat %0b, wanted %0b",
								beat.last_beat, want.last_beat));
					end
				end
				if (stall_hold)
					beat.ready <= 1'b0;
				else
					beat.ready <= !sink_idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin : run_guard
		#RUN_LIMIT_NS;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		pix.valid       <= 1'b0;
		pix.pixel_x     <= '0;
		pix.pixel_y     <= '0;
		pix.pixel_color <= '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_random_pixels(200);
		test_output_hold();
		test_steady_stream(30);

		// Nothing more is offered; every owed beat must arrive and nothing may follow.
		wait_drained();
		repeat (DRAIN_TAIL)
			@(posedge clk);

		$display("Sent %0d pixels on the panel and %0d off it; %0d beats compared, %0d mismatches.",
			pixels_in_panel, pixels_off_panel, beats_checked, err_count);
		$display("Covered panel edges, signed extremes, random idling, %s",
			"a long output stall and full-rate streaming.");
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
